// File: sv/nbpd_pkg.sv
// Shared types and constants for the neighbourhood prefix decomposer.
`timescale 1ns / 1ps

package nbpd_pkg;

    localparam int CENTER_BITS = 32;
    localparam int BASE_BITS   = 32;
    localparam int WILD_BITS   = 6;
    localparam int RADIUS_BITS = 16;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd50;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;   // take a new centre, form the clamped ends
        logic prep;   // form the interval length
        logic step;   // emit one prefix into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last;   // the prefix being formed closes the interval
    } t_status;

endpackage

// File: sv/nbpd_ifs.sv
// Channel interfaces: centre requests, prefix results and radius writes.
`timescale 1ns / 1ps

interface nbpd_in_if;
    logic                               valid;
    logic                               ready;
    logic [nbpd_pkg::CENTER_BITS-1:0]   center_value;

    modport source (output valid, output center_value, input ready);
    modport sink   (input valid, input center_value, output ready);
endinterface

interface nbpd_out_if;
    logic                               valid;
    logic                               ready;
    logic [nbpd_pkg::BASE_BITS-1:0]     prefix_base;
    logic [nbpd_pkg::WILD_BITS-1:0]     wildcard_count;
    logic                               last_prefix;

    modport source (output valid, output prefix_base, output wildcard_count,
                    output last_prefix, input ready);
    modport sink   (input valid, input prefix_base, input wildcard_count,
                    input last_prefix, output ready);
endinterface

interface nbpd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [nbpd_pkg::RADIUS_BITS-1:0]   search_radius;

    modport source (output valid, output search_radius, input ready);
    modport sink   (input valid, input search_radius, output ready);
endinterface

// File: sv/neighborhood_prefix_decomposer_unit.sv
// Top level of the neighbourhood prefix decomposer.
`timescale 1ns / 1ps

// Each centre request opens the interval [centre - radius, centre + radius],
// clamped to 0 and 2^VALUE_BITS - 1, and returns the fewest aligned
// power-of-two blocks covering it in ascending order, the final one flagged
// last_prefix. A request is set up first with the clamped ends, then the
// length, and then yields one prefix per step, n prefixes in all (n is 1
// to 34); the prefix step and the single output register pace the run,
// and a stalled output holds the step. The next centre is taken as soon as
// the last prefix of the current one sits in the output register. The radius
// (reset 50) is written through the configuration channel, which is always
// ready; write it only between requests.

module neighborhood_prefix_decomposer_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbpd_in_if.sink     i_in,
    nbpd_out_if.source  o_out,
    nbpd_cfg_if.sink    i_cfg
);

    nbpd_pkg::t_cmd    cmd;
    nbpd_pkg::t_status status;
    logic              in_ready;
    logic              cfg_we;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    nbpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    nbpd_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_radius     (i_cfg.search_radius),
        .i_center         (i_in.center_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_prefix_base    (o_out.prefix_base),
        .o_wildcard_count (o_out.wildcard_count),
        .o_last_prefix    (o_out.last_prefix)
    );

endmodule

// File: sv/nbpd_ctrl.sv
// Sequencer: accepts a centre, prepares the interval, then steps out prefixes.
`timescale 1ns / 1ps

module nbpd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  nbpd_pkg::t_status   i_status,
    output nbpd_pkg::t_cmd      o_cmd
);

    nbpd_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Output register can take a new prefix when empty or being drained
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nbpd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            nbpd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = nbpd_pkg::ST_PREP;
                end
            end
            nbpd_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = nbpd_pkg::ST_RUN;
            end
            nbpd_pkg::ST_RUN: begin
                if (out_free) begin
                    o_cmd.step  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_status.last) begin
                        n_state = nbpd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = nbpd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/nbpd_dp.sv
// Datapath: radius register, interval ends, largest aligned block per step.
`timescale 1ns / 1ps

module nbpd_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nbpd_pkg::RADIUS_BITS-1:0]    i_cfg_radius,
    input  logic [nbpd_pkg::CENTER_BITS-1:0]    i_center,
    input  nbpd_pkg::t_cmd                      i_cmd,
    output nbpd_pkg::t_status                   o_status,
    output logic [nbpd_pkg::BASE_BITS-1:0]      o_prefix_base,
    output logic [nbpd_pkg::WILD_BITS-1:0]      o_wildcard_count,
    output logic                                o_last_prefix
);

    localparam int LW = VALUE_BITS + 1;  // holds 2^VALUE_BITS
    localparam int SW = ((VALUE_BITS > nbpd_pkg::RADIUS_BITS) ?
                         VALUE_BITS : nbpd_pkg::RADIUS_BITS) + 1;
    localparam int KW = $clog2(VALUE_BITS + 1);
    localparam logic [SW-1:0] VMAX = SW'((LW'(1) << VALUE_BITS) - LW'(1));

    logic [nbpd_pkg::RADIUS_BITS-1:0] r_radius;
    logic [LW-1:0]                    r_lo, n_lo;
    logic [VALUE_BITS-1:0]            r_hi, n_hi;
    logic [LW-1:0]                    r_len, n_len;
    logic [nbpd_pkg::BASE_BITS-1:0]   r_base;
    logic [nbpd_pkg::WILD_BITS-1:0]   r_wild;
    logic                             r_last;

    logic [SW-1:0]  x_ext, r_ext, sum;
    logic [KW-1:0]  k_tz, k_len, k;
    logic [LW-1:0]  blk_size;
    logic           last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= nbpd_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_radius;
        end
    end

    // Clamped interval ends
    assign x_ext = SW'(i_center[VALUE_BITS-1:0]);
    assign r_ext = SW'(r_radius);
    assign sum   = x_ext + r_ext;

    always_comb begin
        n_lo = (x_ext >= r_ext) ? LW'(x_ext - r_ext) : '0;
        n_hi = (sum > VMAX) ? VMAX[VALUE_BITS-1:0] : sum[VALUE_BITS-1:0];
    end

    // Alignment of the left end, capped at the full width when it is zero
    always_comb begin
        k_tz = KW'(VALUE_BITS);
        for (int i = VALUE_BITS - 1; i >= 0; i--) begin
            if (r_lo[i]) begin
                k_tz = KW'(i);
            end
        end
    end

    // Floor of log2 of the remaining length
    always_comb begin
        k_len = '0;
        for (int i = 0; i < LW; i++) begin
            if (r_len[i]) begin
                k_len = KW'(i);
            end
        end
    end

    assign k        = (k_tz < k_len) ? k_tz : k_len;
    assign blk_size = LW'(1) << k;
    assign last     = (blk_size == r_len);

    always_comb begin
        n_len = r_len;
        if (i_cmd.prep) begin
            n_len = LW'({1'b0, r_hi}) - r_lo + LW'(1);
        end else if (i_cmd.step) begin
            n_len = r_len - blk_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end else if (i_cmd.step) begin
            r_lo <= r_lo + blk_size;
        end
        r_len <= n_len;
        if (i_cmd.step) begin
            r_base <= nbpd_pkg::BASE_BITS'(r_lo[VALUE_BITS-1:0]);
            r_wild <= nbpd_pkg::WILD_BITS'(k);
            r_last <= last;
        end
    end

    assign o_status.last    = last;
    assign o_prefix_base    = r_base;
    assign o_wildcard_count = r_wild;
    assign o_last_prefix    = r_last;

endmodule

// File: tb/nbpd_prefix_check.sv
// Prefix run predictor and result comparison for the neighbourhood prefix decomposer.
`timescale 1ns / 1ps

module nbpd_prefix_check
    import nbpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    nbpd_in_if      i_in_ch,
    nbpd_out_if     i_out_ch,
    nbpd_cfg_if     i_cfg_ch,
    output int      o_fail_count,
    output int      o_pending
);

    localparam int          MAX_RUN   = 34;
    localparam logic [33:0] VALUE_MAX = (34'd1 << CENTER_BITS) - 34'd1;

    typedef struct packed {
        logic [BASE_BITS-1:0] base;
        logic [WILD_BITS-1:0] wild;
        logic                 last;
    } t_prefix;

    t_prefix                pending_prefixes[$];
    logic [RADIUS_BITS-1:0] radius;

    // Queue the aligned blocks covering [centre - rad, centre + rad], clamped.
    // Two spare bits keep the top of the range from wrapping.
    function automatic void expand_neighbourhood(input logic [CENTER_BITS-1:0] centre,
                                                 input logic [RADIUS_BITS-1:0] rad);
        logic [33:0] lo;
        logic [33:0] hi;
        logic [33:0] blk;
        int          k;
        int          n;
        t_prefix     p;
        lo = (centre >= rad) ? 34'(centre) - 34'(rad) : 34'd0;
        hi = 34'(centre) + 34'(rad);
        if (hi > VALUE_MAX)
            hi = VALUE_MAX;
        n = 0;
        while (lo <= hi && n < MAX_RUN) begin
            k = 0;
            while (k < CENTER_BITS) begin
                blk = 34'd1 << (k + 1);
                if ((lo & (blk - 34'd1)) != 34'd0)
                    break;
                if (lo + blk - 34'd1 > hi)
                    break;
                k++;
            end
            blk    = 34'd1 << k;
            p.base = lo[BASE_BITS-1:0];
            p.wild = k[WILD_BITS-1:0];
            p.last = (lo + blk - 34'd1 == hi);
            pending_prefixes = {pending_prefixes, p};
            lo += blk;
            n++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_prefix want;
        if (!i_rst_n) begin
            radius = RADIUS_RESET;
            pending_prefixes.delete();
        end else begin
            // results first: a new request may be taken on the edge that
            // retires the previous run's last prefix
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (pending_prefixes.size() == 0) begin
                    $error("unexpected prefix: base %h wild %0d last %0b",
                           i_out_ch.prefix_base, i_out_ch.wildcard_count,
                           i_out_ch.last_prefix);
                    o_fail_count++;
                end else begin
                    want = pending_prefixes.pop_front();
                    if (i_out_ch.prefix_base !== want.base) begin
                        $error("prefix_base: expected %h, got %h",
                               want.base, i_out_ch.prefix_base);
                        o_fail_count++;
                    end
                    if (i_out_ch.wildcard_count !== want.wild) begin
                        $error("wildcard_count: expected %0d, got %0d",
                               want.wild, i_out_ch.wildcard_count);
                        o_fail_count++;
                    end
                    if (i_out_ch.last_prefix !== want.last) begin
                        $error("last_prefix: expected %0b, got %0b",
                               want.last, i_out_ch.last_prefix);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_ch.valid && i_in_ch.ready)
                expand_neighbourhood(i_in_ch.center_value, radius);
            if (i_cfg_ch.valid && i_cfg_ch.ready)
                radius = i_cfg_ch.search_radius;
        end
        o_pending = pending_prefixes.size();
    end

endmodule

// File: tb/testbench.sv
// Stimulus, reset, watchdog and verdict for the neighbourhood prefix decomposer.
`timescale 1ns / 1ps

module testbench;
    import nbpd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    bit   steady;       // no idling on either side while set
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    nbpd_in_if  in_ch ();
    nbpd_out_if out_ch ();
    nbpd_cfg_if cfg_ch ();

    neighborhood_prefix_decomposer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    nbpd_prefix_check chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        out_ch.ready = steady || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_centre(input logic [CENTER_BITS-1:0] centre);
        while (!steady && $urandom_range(99) < 6) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.center_value = centre;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off until every prefix has come back, then let the pipeline settle.
    task automatic drain_runs();
        in_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_radius(input logic [RADIUS_BITS-1:0] rad);
        drain_runs();
        cfg_ch.valid         = 1'b1;
        cfg_ch.search_radius = rad;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Bias towards the clamped ends and aligned centres.
    function automatic logic [CENTER_BITS-1:0] pick_centre(input int unsigned rad);
        case ($urandom_range(7))
            0:       return $urandom_range(rad + 2);
            1:       return 32'hFFFF_FFFF - $urandom_range(rad + 2);
            2:       return $urandom & ~((32'd1 << $urandom_range(20)) - 32'd1);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [CENTER_BITS-1:0] at_reset_radius[7];
        logic [CENTER_BITS-1:0] zero_radius[3];
        logic [CENTER_BITS-1:0] full_radius[7];
        logic [CENTER_BITS-1:0] unit_radius[3];
        logic [RADIUS_BITS-1:0] rad;

        at_reset_radius = '{32'd0, 32'd49, 32'd50, 32'hFFFF_FFFF, 32'hFFFF_FFCD,
                            32'h8000_0000, 32'h1234_5678};
        zero_radius     = '{32'd0, 32'hFFFF_FFFF, 32'hA5A5_A5A5};
        full_radius     = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0001_0000, 32'hFFFF_0000, 32'h5A5A_5A5B};
        unit_radius     = '{32'd0, 32'hFFFF_FFFF, 32'd2};

        in_ch.valid          = 1'b0;
        in_ch.center_value   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.search_radius = '0;
        steady               = 1'b0;
        i_rst_n              = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset radius, then radius zero, the widest radius and one
        foreach (at_reset_radius[i])
            send_centre(at_reset_radius[i]);
        write_radius(16'd0);
        foreach (zero_radius[i])
            send_centre(zero_radius[i]);
        write_radius(16'hFFFF);
        foreach (full_radius[i])
            send_centre(full_radius[i]);
        write_radius(16'd1);
        foreach (unit_radius[i])
            send_centre(unit_radius[i]);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1:       rad = 16'($urandom_range(15));
                2:       rad = 16'hFFFF;
                4:       rad = 16'($urandom_range(255));
                default: rad = 16'($urandom);
            endcase
            write_radius(rad);
            steady = (phase == 2);
            for (int n = 0; n < 16; n++)
                send_centre(pick_centre(rad));
            drain_runs();
            steady = 1'b0;
        end

        drain_runs();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
